### design/key_gesture_classifier_defines.svh
// Assertion macros shared by the key gesture classifier modules.
`ifndef KEY_GESTURE_CLASSIFIER_DEFINES_SVH
`define KEY_GESTURE_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent and consequent checked on the same edge.
`define KGC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kgc: same-cycle check failed");
// Consequent checked on the edge after the antecedent.
`define KGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kgc: next-cycle check failed");
`else
`define KGC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define KGC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### design/kgc_pkg.sv
// Types and constants for the key gesture classifier.
`timescale 1ns / 1ps
`default_nettype none
package kgc_pkg;

    localparam int KEY_W      = 8;
    localparam int PERIOD_W   = 8;
    localparam int WINDOW_W   = 16;
    localparam int MODE_W     = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int TIMER_BITS_DEF = 16;
    localparam int TIMER_RST      = 500;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_KEY    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME     = 8'd3;

    // Reset values of the configuration registers
    localparam logic [KEY_W-1:0]    TARGET_KEY_RST    = 8'd4;
    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST   = 8'd10;
    localparam logic [WINDOW_W-1:0] DOUBLE_WINDOW_RST = 16'd500;
    localparam logic [WINDOW_W-1:0] LONG_TIME_RST     = 16'd1000;

    // Mode byte toggle masks
    localparam logic [MODE_W-1:0] RELEASE_BIT = 5'h01;
    localparam logic [MODE_W-1:0] DOUBLE_BIT  = 5'h02;
    localparam logic [MODE_W-1:0] LONG_BIT    = 5'h04;
    localparam logic [MODE_W-1:0] PRESS_BIT   = 5'h10;

    localparam logic [PERIOD_W-1:0] DIV_MAX = '1;

    typedef struct packed {
        logic [KEY_W-1:0]    target_key;
        logic [PERIOD_W-1:0] scan_period;
        logic [WINDOW_W-1:0] double_window;
        logic [WINDOW_W-1:0] long_time;
    } cfg_t;

    typedef struct packed {
        logic press;
        logic release_edge;
        logic dbl;
        logic lng;
    } flags_t;

endpackage
`default_nettype wire

### design/kgc_cfg.sv
// Configuration register file of the key gesture classifier.
`timescale 1ns / 1ps
`default_nettype none
module kgc_cfg
    import kgc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_TARGET_KEY:    cfg_next.target_key    = cfg_data[KEY_W-1:0];
                REG_SCAN_PERIOD:   cfg_next.scan_period   = cfg_data[PERIOD_W-1:0];
                REG_DOUBLE_WINDOW: cfg_next.double_window = cfg_data[WINDOW_W-1:0];
                REG_LONG_TIME:     cfg_next.long_time     = cfg_data[WINDOW_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_key    <= TARGET_KEY_RST;
            cfg_reg.scan_period   <= SCAN_PERIOD_RST;
            cfg_reg.double_window <= DOUBLE_WINDOW_RST;
            cfg_reg.long_time     <= LONG_TIME_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### design/kgc_core.sv
// Gesture state: scan divider, last key, gesture timer, mode byte and their update.
`timescale 1ns / 1ps
`default_nettype none
`include "key_gesture_classifier_defines.svh"
module kgc_core
    import kgc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [KEY_W-1:0] key_code,
    input  wire cfg_t             cfg,
    output logic [MODE_W-1:0]     res_mode,
    output flags_t                res_flags
);

    localparam int CMP_W = (TIMER_BITS > WINDOW_W) ? TIMER_BITS : WINDOW_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    logic [PERIOD_W-1:0]   div_reg,   div_next;
    logic [KEY_W-1:0]      last_reg,  last_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [MODE_W-1:0]     mode_reg,  mode_next;

    logic [PERIOD_W-1:0]   div_inc;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [TIMER_BITS-1:0] timer_pressed;
    logic                  scan;
    logic                  changed;
    flags_t                flags;

    always_comb begin
        div_inc   = (div_reg == DIV_MAX) ? div_reg : div_reg + 1'b1;
        timer_inc = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 1'b1;
        scan      = (div_inc >= cfg.scan_period);
        changed   = (key_code != last_reg);

        flags.press        = scan && changed && (key_code == cfg.target_key);
        flags.release_edge = scan && changed && (last_reg == cfg.target_key);
        flags.dbl          = flags.press &&
                             (CMP_W'(timer_inc) < CMP_W'(cfg.double_window));
        // a press restarts the timer before the long-press check
        timer_pressed      = flags.press ? '0 : timer_inc;
        flags.lng          = scan && (key_code == cfg.target_key) &&
                             (CMP_W'(timer_pressed) > CMP_W'(cfg.long_time));

        div_next   = scan ? '0 : div_inc;
        last_next  = scan ? key_code : last_reg;
        timer_next = flags.lng ? '0 : timer_pressed;
        mode_next  = mode_reg
                   ^ (flags.press        ? PRESS_BIT   : '0)
                   ^ (flags.dbl          ? DOUBLE_BIT  : '0)
                   ^ (flags.release_edge ? RELEASE_BIT : '0)
                   ^ (flags.lng          ? LONG_BIT    : '0);
    end

    assign res_mode  = mode_next;
    assign res_flags = flags;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg   <= '0;
            last_reg  <= '0;
            timer_reg <= TIMER_BITS'(TIMER_RST);
            mode_reg  <= '0;
        end else if (step) begin
            div_reg   <= div_next;
            last_reg  <= last_next;
            timer_reg <= timer_next;
            mode_reg  <= mode_next;
        end
    end

    `KGC_ASSERT_NEXT(a_press_toggles, aclk, aresetn, step && flags.press, mode_reg[4] != $past(mode_reg[4]))
    `KGC_ASSERT_NEXT(a_idle_tick_keeps, aclk, aresetn, step && !scan, $stable(mode_reg) && $stable(last_reg))
    `KGC_ASSERT_NEXT(a_gesture_clears_timer, aclk, aresetn, step && (flags.press || flags.lng), timer_reg == '0)

endmodule
`default_nettype wire

### design/key_gesture_classifier.sv
// Top level of the key gesture classifier: input register, gesture core, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "key_gesture_classifier_defines.svh"
// Key gesture classifier. Each input item is one millisecond tick carrying the
// raw key code (0 = no key); each item produces exactly one result item with
// the 5-bit mode byte after that tick and four flags (press, release, double
// click, long press), which are 0 on ticks where no key scan happens. A scan
// occurs when the saturating tick divider reaches scan_period; it then
// compares the key with the last scanned key. A press of target_key toggles
// mode bit 4, plus bit 1 if it came within double_window ticks of the last
// gesture; a release toggles bit 0; holding past long_time toggles bit 2 and
// restarts the timer, so it repeats during a long hold. The gesture timer is
// TIMER_BITS wide and saturates. Timing: an item is taken into an input
// register, goes through the combinational core update, and lands in the
// result register (two register stages from s_ ports to m_ ports); throughput
// is one item per cycle while m_ready is high; m_ready is the only stall source.
// Configuration registers (index: 0 target_key, 1 scan_period,
// 2 double_window, 3 long_time) are written over the cfg_ channel, which is
// always ready; write them only while no item is in flight. Other indexes
// are ignored.
module key_gesture_classifier
    import kgc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // tick input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [KEY_W-1:0]      s_key_code,
    // result output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [MODE_W-1:0]          m_mode_bits,
    output logic                       m_press_seen,
    output logic                       m_release_seen,
    output logic                       m_double_seen,
    output logic                       m_long_seen,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                cfg;
    logic                in_valid_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                out_valid_reg;
    logic [MODE_W-1:0]   mode_out_reg;
    flags_t              flags_out_reg;
    logic                step;
    logic [MODE_W-1:0]   res_mode;
    flags_t              res_flags;

    kgc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held tick moves on whenever the result register is free or draining.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    kgc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .key_code  (key_reg),
        .cfg       (cfg),
        .res_mode  (res_mode),
        .res_flags (res_flags)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg <= s_key_code;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            mode_out_reg  <= res_mode;
            flags_out_reg <= res_flags;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_mode_bits    = mode_out_reg;
    assign m_press_seen   = flags_out_reg.press;
    assign m_release_seen = flags_out_reg.release_edge;
    assign m_double_seen  = flags_out_reg.dbl;
    assign m_long_seen    = flags_out_reg.lng;

    `KGC_ASSERT_NEXT(a_stalled_result_kept, aclk, aresetn, out_valid_reg && !m_ready, out_valid_reg)
    `KGC_ASSERT_SAME(a_mode_bit3_zero, aclk, aresetn, out_valid_reg, !m_mode_bits[3])

endmodule
`default_nettype wire
